>>> rtl/ddn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddn_pkg
// Shared widths, error codes and month tables for the date-to-day-number core.
// ----------------------------------------------------------------------------
package ddn_pkg;

  localparam int CodeW  = 27;
  localparam int CountW = 22;
  localparam int ErrW   = 3;
  localparam int YearW  = 14;
  localparam int QuoW   = 14;
  localparam int DayW   = 8;
  localparam int MonW   = 7;
  localparam int CentW  = 7;

  // Reciprocal of 10000 scaled by 2**35 (floor), and of 100 scaled by 2**20.
  localparam int RecipW10k  = 22;
  localparam int Shift10k   = 35;
  localparam int Recip10k   = 3435973;
  localparam int RecipW100  = 14;
  localparam int Shift100   = 20;
  localparam int Recip100   = 10485;

  typedef enum logic [ErrW-1:0] {
    ERR_OK        = 3'd0,
    ERR_NOT_POS   = 3'd1,
    ERR_BAD_YEAR  = 3'd2,
    ERR_BAD_MONTH = 3'd3,
    ERR_BAD_DAY   = 3'd4
  } err_t;

  // Days of the month for a valid month 1..12.
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] d;
    case (month)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  // Days in the whole months before a valid month, common year.
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/decimal_date_to_day_number_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_date_to_day_number_core
// Converts a ddmmyyyy decimal date into a Gregorian day number with checks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  (valid, ready, date_code): one transaction carries one
//   date packed as day*1000000 + month*10000 + year.
//   Output channel (out_valid, out_ready, day_count, error_code): one
//   transaction per input, in input order. day_count is the day number with
//   1 January of year 1 as day 1, or 0 when error_code is not ERR_OK.
// Throughput: one transaction per cycle. The six-stage pipeline advances
//   as a whole every cycle unless the output stalls; the reciprocal multiply
//   for the divide by 10000 in the first stage is the deepest logic and sets
//   the clock period, the other stages are balanced against it.
// Stall: while out_valid is high and out_ready is low, the whole pipeline
//   holds and ready drops; nothing is lost or repeated.
// Reset: rst (synchronous, active high) clears all stage valid bits and
//   holds ready low; the pipeline is empty and ready is high in the cycle
//   after reset.
// ----------------------------------------------------------------------------
module decimal_date_to_day_number_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             valid,
  output logic                             ready,
  input  logic [ddn_pkg::CodeW-1:0]        date_code,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ddn_pkg::CountW-1:0]       day_count,
  output logic [ddn_pkg::ErrW-1:0]         error_code
);

  localparam int ProdW1 = ddn_pkg::CodeW + ddn_pkg::RecipW10k;
  localparam int ProdW3 = ddn_pkg::QuoW + ddn_pkg::RecipW100;

  logic advance;
  logic [6:1] vld;

  // Stage 1: reciprocal multiply for the divide by 10000.
  logic [ddn_pkg::CodeW-1:0] s1_code;
  logic [ProdW1-1:0]         s1_prod;
  logic                      s1_zero;

  // Stage 2: correct quotient and remainder.
  logic [ddn_pkg::QuoW-1:0]  s2_quo_est;
  logic [ddn_pkg::CodeW-1:0] s2_rem_est;
  logic [ddn_pkg::QuoW-1:0]  s2_quo;
  logic [ddn_pkg::YearW-1:0] s2_year;
  logic                      s2_zero;
  logic [ddn_pkg::QuoW-1:0]  q_year_next;

  // Stage 3: reciprocal multiplies for the two divides by 100.
  logic [ProdW3-1:0]         s3_qprod;
  logic [ProdW3-1:0]         s3_yprod;
  logic [ddn_pkg::QuoW-1:0]  s3_quo;
  logic [ddn_pkg::YearW-1:0] s3_year;
  logic                      s3_zero;

  // Stage 4: corrected day, month, century and year within century.
  logic [ddn_pkg::DayW-1:0]  dq_est;
  logic [ddn_pkg::QuoW-1:0]  dq_rem;
  logic [ddn_pkg::CentW-1:0] cq_est;
  logic [ddn_pkg::YearW-1:0] cq_rem;
  logic [ddn_pkg::DayW-1:0]  s4_day;
  logic [ddn_pkg::MonW-1:0]  s4_month;
  logic [ddn_pkg::CentW-1:0] s4_cent;
  logic [ddn_pkg::CentW-1:0] s4_yrem;
  logic [ddn_pkg::YearW-1:0] s4_year;
  logic                      s4_zero;

  // Stage 5: checks, whole-year days, days before the month.
  logic                       leap;
  logic [ddn_pkg::YearW-1:0]  prev_year;
  logic [ddn_pkg::CentW-1:0]  prev_cent;
  logic [4:0]                 mdays;
  ddn_pkg::err_t              err_next;
  logic [ddn_pkg::CountW-1:0] year_days_next;
  logic [8:0]                 mon_days_next;
  ddn_pkg::err_t              s5_err;
  logic [ddn_pkg::CountW-1:0] s5_year_days;
  logic [8:0]                 s5_mon_days;
  logic [ddn_pkg::DayW-1:0]   s5_day;

  // Stage 6: output register.
  logic [ddn_pkg::CountW-1:0] count_next;

  // Move the whole pipeline unless the output is full and stalled.
  assign advance = !vld[6] || out_ready;
  assign ready   = advance && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[5:1], valid};
    end
  end

  // ---- Stage 1 ----
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_code <= date_code;
      s1_prod <= ProdW1'(date_code) * ProdW1'(ddn_pkg::Recip10k);
      s1_zero <= (date_code == '0);
    end
  end

  // ---- Stage 2 ----
  // The estimate is the true quotient or one below it.
  assign s2_quo_est = s1_prod[ddn_pkg::Shift10k +: ddn_pkg::QuoW];
  assign s2_rem_est = s1_code - ddn_pkg::CodeW'(s2_quo_est) * ddn_pkg::CodeW'(10000);
  assign q_year_next = (s2_rem_est >= ddn_pkg::CodeW'(10000))
                       ? ddn_pkg::QuoW'(s2_rem_est - ddn_pkg::CodeW'(10000))
                       : ddn_pkg::QuoW'(s2_rem_est);

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_quo  <= (s2_rem_est >= ddn_pkg::CodeW'(10000)) ? s2_quo_est + 1'b1 : s2_quo_est;
      s2_year <= q_year_next;
      s2_zero <= s1_zero;
    end
  end

  // ---- Stage 3 ----
  always_ff @(posedge clk) begin
    if (advance) begin
      s3_qprod <= ProdW3'(s2_quo) * ProdW3'(ddn_pkg::Recip100);
      s3_yprod <= ProdW3'(s2_year) * ProdW3'(ddn_pkg::Recip100);
      s3_quo   <= s2_quo;
      s3_year  <= s2_year;
      s3_zero  <= s2_zero;
    end
  end

  // ---- Stage 4 ----
  assign dq_est = s3_qprod[ddn_pkg::Shift100 +: ddn_pkg::DayW];
  assign dq_rem = s3_quo - ddn_pkg::QuoW'(dq_est) * ddn_pkg::QuoW'(100);
  assign cq_est = s3_yprod[ddn_pkg::Shift100 +: ddn_pkg::CentW];
  assign cq_rem = s3_year - ddn_pkg::YearW'(cq_est) * ddn_pkg::YearW'(100);

  always_ff @(posedge clk) begin
    if (advance) begin
      if (dq_rem >= ddn_pkg::QuoW'(100)) begin
        s4_day   <= dq_est + 1'b1;
        s4_month <= ddn_pkg::MonW'(dq_rem - ddn_pkg::QuoW'(100));
      end else begin
        s4_day   <= dq_est;
        s4_month <= ddn_pkg::MonW'(dq_rem);
      end
      if (cq_rem >= ddn_pkg::YearW'(100)) begin
        s4_cent <= cq_est + 1'b1;
        s4_yrem <= ddn_pkg::CentW'(cq_rem - ddn_pkg::YearW'(100));
      end else begin
        s4_cent <= cq_est;
        s4_yrem <= ddn_pkg::CentW'(cq_rem);
      end
      s4_year <= s3_year;
      s4_zero <= s3_zero;
    end
  end

  // ---- Stage 5 ----
  // Leap: divisible by 4, and not a century unless the century divides by 4.
  assign leap = (s4_year[1:0] == 2'b00) && ((s4_yrem != '0) || (s4_cent[1:0] == 2'b00));
  assign mdays = ddn_pkg::month_days(s4_month[3:0], leap);
  assign prev_year = s4_year - 1'b1;
  // (year - 1) / 100 drops by one exactly at a century year.
  assign prev_cent = (s4_yrem == '0) ? s4_cent - 1'b1 : s4_cent;

  always_comb begin
    if (s4_zero) begin
      err_next = ddn_pkg::ERR_NOT_POS;
    end else if (s4_year == '0) begin
      err_next = ddn_pkg::ERR_BAD_YEAR;
    end else if (s4_month == '0 || s4_month > ddn_pkg::MonW'(12)) begin
      err_next = ddn_pkg::ERR_BAD_MONTH;
    end else if (s4_day == '0 || s4_day > ddn_pkg::DayW'(mdays)) begin
      err_next = ddn_pkg::ERR_BAD_DAY;
    end else begin
      err_next = ddn_pkg::ERR_OK;
    end
  end

  assign year_days_next = ddn_pkg::CountW'(prev_year) * ddn_pkg::CountW'(365)
                        + ddn_pkg::CountW'(prev_year >> 2)
                        - ddn_pkg::CountW'(prev_cent)
                        + ddn_pkg::CountW'(prev_cent >> 2);
  assign mon_days_next = ddn_pkg::days_before(s4_month[3:0])
                       + ((leap && s4_month > ddn_pkg::MonW'(2)) ? 9'd1 : 9'd0);

  always_ff @(posedge clk) begin
    if (advance) begin
      s5_err       <= err_next;
      s5_year_days <= year_days_next;
      s5_mon_days  <= mon_days_next;
      s5_day       <= s4_day;
    end
  end

  // ---- Stage 6 ----
  // Drop the count to zero on any error.
  assign count_next = (s5_err == ddn_pkg::ERR_OK)
                      ? s5_year_days + ddn_pkg::CountW'(s5_mon_days)
                        + ddn_pkg::CountW'(s5_day)
                      : '0;

  always_ff @(posedge clk) begin
    if (advance) begin
      day_count  <= count_next;
      error_code <= s5_err;
    end
  end

  assign out_valid = vld[6];

endmodule
